// ----- src/jsu_pkg.sv -----
// jsu_pkg: shared types and constants for the JSON string unescaper.
// Used by jsu_front, jsu_queue, jsu_back and the top level.
package jsu_pkg;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // One queued request from the parser to the output side.
    // raw: emit cp[7:0] as is; otherwise a data request is a code point to encode.
    typedef struct packed {
        logic [1:0]  kind;
        logic        raw;
        logic [20:0] cp;
    } job_t;

endpackage

// ----- src/json_string_unescape_utf8.sv -----
// json_string_unescape_utf8: top level of the JSON string unescaper.
// Instantiates jsu_front, jsu_queue and jsu_back; depends on jsu_pkg.
//
// Input stream s_*: one text byte per request in s_tdata[7:0]; s_tlast set
// means the text has ended and the byte is ignored. Output stream m_*: one
// result per request, byte in m_tdata[7:0], kind in m_tuser (0 data,
// 1 string complete, 2 error), m_tlast on the final result of an input byte.
// Input is taken at one byte per cycle while the job queue has room; the
// parser classifies each byte in the cycle it is taken. Results pass through
// the job queue and output register, one per cycle while m_tready is high. A
// \u escape takes six input bytes and yields at most three, a surrogate pair
// twelve and four, so with m_tready held high the output keeps pace, the
// queue (QUEUE_DEPTH jobs) never fills and s_tready stays high. When m_tready
// is low the output register holds its result and the queue absorbs further
// jobs until full, then s_tready drops. Reset clears the parser to waiting
// for an opening quote and empties the queue and output register.
module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // input_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [1:0] kind
    output logic       m_tlast    // last
);

    logic q_full;
    logic q_empty;
    logic q_pop;
    logic push;
    job_t push_job;
    job_t q_head;

    jsu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_byte   (s_tdata),
        .input_end (s_tlast),
        .q_full    (q_full),
        .in_ready  (s_tready),
        .push      (push),
        .push_job  (push_job)
    );

    jsu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    jsu_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_kind  (m_tuser),
        .out_last  (m_tlast)
    );

`ifndef SYNTHESIS
    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_DATA |-> m_tlast && m_tdata == 8'h00)
        else $error("complete/error result not alone or carries data");

    a_kind_known: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser == KIND_DATA || m_tuser == KIND_DONE
                     || m_tuser == KIND_ERROR)
        else $error("undefined result kind");

    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("input stalled without a request taken");
`endif

endmodule

// ----- src/jsu_front.sv -----
// jsu_front: accepts text bytes, tracks string/escape/surrogate state and
// pushes one job per request that causes output. Depends on jsu_pkg.
module jsu_front
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       input_end,
    input  logic       q_full,
    output logic       in_ready,
    output logic       push,
    output job_t       push_job
);

    localparam logic [2:0] M_IDLE   = 3'd0;
    localparam logic [2:0] M_STR    = 3'd1;
    localparam logic [2:0] M_ESC    = 3'd2;
    localparam logic [2:0] M_HEX1   = 3'd3;
    localparam logic [2:0] M_WANTBS = 3'd4;
    localparam logic [2:0] M_WANTU  = 3'd5;
    localparam logic [2:0] M_HEX2   = 3'd6;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    logic [2:0]  mode_reg, mode_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [15:0] code_accum_reg, code_accum_next;
    logic [9:0]  high_half_reg, high_half_next;

    logic        accept;
    logic        do_fail;
    logic        hex_ok;
    logic [3:0]  hex_digit;
    logic [15:0] hex_val;

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign {hex_ok, hex_digit} = hex_decode(in_byte);
    assign hex_val = {code_accum_reg[11:0], hex_digit};

    always_comb
    begin
        mode_next       = mode_reg;
        hex_count_next  = hex_count_reg;
        code_accum_next = code_accum_reg;
        high_half_next  = high_half_reg;
        push            = 1'b0;
        push_job        = '0;
        do_fail         = 1'b0;
        if (accept)
        begin
            if (mode_reg == M_IDLE || mode_reg > M_HEX2)
            begin
                if (!input_end && in_byte == CH_QUOTE)
                begin
                    mode_next       = M_STR;
                    hex_count_next  = 2'd0;
                    code_accum_next = 16'd0;
                    high_half_next  = 10'd0;
                end
                else
                begin
                    mode_next = M_IDLE;
                end
            end
            else if (input_end)
            begin
                do_fail = 1'b1;
            end
            else
            begin
                case (mode_reg)
                    M_STR:
                    begin
                        if (in_byte == CH_QUOTE)
                        begin
                            mode_next       = M_IDLE;
                            hex_count_next  = 2'd0;
                            code_accum_next = 16'd0;
                            high_half_next  = 10'd0;
                            push            = 1'b1;
                            push_job.kind   = KIND_DONE;
                            push_job.raw    = 1'b1;
                        end
                        else if (in_byte == CH_BSL)
                        begin
                            mode_next = M_ESC;
                        end
                        else if (in_byte < 8'h20)
                        begin
                            do_fail = 1'b1;
                        end
                        else
                        begin
                            push          = 1'b1;
                            push_job.kind = KIND_DATA;
                            push_job.raw  = 1'b1;
                            push_job.cp   = {13'd0, in_byte};
                        end
                    end
                    M_ESC:
                    begin
                        push_job.kind = KIND_DATA;
                        push_job.raw  = 1'b1;
                        mode_next     = M_STR;
                        push          = 1'b1;
                        case (in_byte)
                            CH_QUOTE: push_job.cp = 21'h22;
                            CH_BSL:   push_job.cp = 21'h5c;
                            CH_SLASH: push_job.cp = 21'h2f;
                            CH_B:     push_job.cp = 21'h08;
                            CH_F:     push_job.cp = 21'h0c;
                            CH_N:     push_job.cp = 21'h0a;
                            CH_R:     push_job.cp = 21'h0d;
                            CH_T:     push_job.cp = 21'h09;
                            CH_U:
                            begin
                                push            = 1'b0;
                                mode_next       = M_HEX1;
                                hex_count_next  = 2'd0;
                                code_accum_next = 16'd0;
                            end
                            default:
                            begin
                                push    = 1'b0;
                                do_fail = 1'b1;
                            end
                        endcase
                    end
                    M_WANTBS:
                    begin
                        if (in_byte == CH_BSL)
                        begin
                            mode_next = M_WANTU;
                        end
                        else
                        begin
                            do_fail = 1'b1;
                        end
                    end
                    M_WANTU:
                    begin
                        if (in_byte == CH_U)
                        begin
                            mode_next       = M_HEX2;
                            hex_count_next  = 2'd0;
                            code_accum_next = 16'd0;
                        end
                        else
                        begin
                            do_fail = 1'b1;
                        end
                    end
                    M_HEX1, M_HEX2:
                    begin
                        if (!hex_ok)
                        begin
                            do_fail = 1'b1;
                        end
                        else if (hex_count_reg != 2'd3)
                        begin
                            code_accum_next = hex_val;
                            hex_count_next  = hex_count_reg + 2'd1;
                        end
                        else if (mode_reg == M_HEX1)
                        begin
                            hex_count_next  = 2'd0;
                            code_accum_next = 16'd0;
                            if (hex_val[15:10] == 6'b110110)
                            begin
                                high_half_next = hex_val[9:0];
                                mode_next      = M_WANTBS;
                            end
                            else if (hex_val[15:10] == 6'b110111)
                            begin
                                do_fail = 1'b1;
                            end
                            else
                            begin
                                mode_next     = M_STR;
                                push          = 1'b1;
                                push_job.kind = KIND_DATA;
                                push_job.cp   = {5'd0, hex_val};
                            end
                        end
                        else
                        begin
                            if (hex_val[15:10] != 6'b110111)
                            begin
                                do_fail = 1'b1;
                            end
                            else
                            begin
                                mode_next       = M_STR;
                                hex_count_next  = 2'd0;
                                code_accum_next = 16'd0;
                                high_half_next  = 10'd0;
                                push            = 1'b1;
                                push_job.kind   = KIND_DATA;
                                push_job.cp     = {{1'b0, high_half_reg} + 11'd64,
                                                   hex_val[9:0]};
                            end
                        end
                    end
                    default:
                    begin
                        mode_next = M_IDLE;
                    end
                endcase
            end
            if (do_fail)
            begin
                mode_next       = M_IDLE;
                hex_count_next  = 2'd0;
                code_accum_next = 16'd0;
                high_half_next  = 10'd0;
                push            = 1'b1;
                push_job        = '0;
                push_job.kind   = KIND_ERROR;
                push_job.raw    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= M_IDLE;
            hex_count_reg  <= 2'd0;
            code_accum_reg <= 16'd0;
            high_half_reg  <= 10'd0;
        end
        else
        begin
            mode_reg       <= mode_next;
            hex_count_reg  <= hex_count_next;
            code_accum_reg <= code_accum_next;
            high_half_reg  <= high_half_next;
        end
    end

endmodule

// ----- src/jsu_queue.sv -----
// jsu_queue: small FIFO of job requests between parser and encoder.
// Depends on jsu_pkg.
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic empty,
    output job_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/jsu_back.sv -----
// jsu_back: takes queue jobs, encodes code points to UTF-8, drives the
// result register one byte per cycle while out_ready is high; uses jsu_pkg.
module jsu_back
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  job_t       q_head,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] out_kind,
    output logic       out_last
);

    logic       valid_reg;
    logic [7:0] byte_reg, byte_next;
    logic [1:0] kind_reg;
    logic       last_reg, last_next;
    logic [1:0] idx_reg, idx_next;
    logic       load;
    logic [1:0] len_m1;
    logic [20:0] cp;

    assign cp = q_head.cp;
    assign load = !q_empty && (!valid_reg || out_ready);

    always_comb
    begin
        if (q_head.raw || q_head.kind != KIND_DATA || cp <= 21'h7f)
        begin
            len_m1 = 2'd0;
        end
        else if (cp <= 21'h7ff)
        begin
            len_m1 = 2'd1;
        end
        else if (cp <= 21'hffff)
        begin
            len_m1 = 2'd2;
        end
        else
        begin
            len_m1 = 2'd3;
        end
    end

    always_comb
    begin
        byte_next = 8'h00;
        case ({len_m1, idx_reg})
            4'b00_00: byte_next = cp[7:0];
            4'b01_00: byte_next = {3'b110, cp[10:6]};
            4'b01_01: byte_next = {2'b10, cp[5:0]};
            4'b10_00: byte_next = {4'b1110, cp[15:12]};
            4'b10_01: byte_next = {2'b10, cp[11:6]};
            4'b10_10: byte_next = {2'b10, cp[5:0]};
            4'b11_00: byte_next = {5'b11110, cp[20:18]};
            4'b11_01: byte_next = {2'b10, cp[17:12]};
            4'b11_10: byte_next = {2'b10, cp[11:6]};
            4'b11_11: byte_next = {2'b10, cp[5:0]};
            default:  byte_next = 8'h00;
        endcase
        last_next = (idx_reg == len_m1);
        idx_next  = idx_reg;
        if (load)
        begin
            idx_next = last_next ? 2'd0 : idx_reg + 2'd1;
        end
    end

    assign q_pop = load && last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_next;
            kind_reg <= q_head.kind;
            last_reg <= last_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_kind  = kind_reg;
    assign out_last  = last_reg;

endmodule
